>>> design/fp64ri_pkg.sv
// Package for fp64_round_to_integral: field widths, constants, mode codes.
// No dependencies.
`default_nettype none
package fp64ri_pkg;
    localparam int unsigned FRAC_W = 52;
    localparam int unsigned EXP_W  = 11;
    localparam logic [EXP_W-1:0] EXP_MAX  = 11'h7FF;
    localparam logic [EXP_W-1:0] EXP_BIAS = 11'd1023;
    localparam logic [62:0] ONE_MAG = {EXP_BIAS, 52'd0};
    localparam int unsigned DEFAULT_STAGES = 3;

    typedef enum logic [2:0] {
        MODE_ZERO = 3'd0,
        MODE_UP   = 3'd1,
        MODE_DOWN = 3'd2,
        MODE_NEAR = 3'd3,
        MODE_AWAY = 3'd4
    } t_mode;
endpackage
`default_nettype wire

>>> design/fp64_round_to_integral.sv
// fp64_round_to_integral: round a binary64 value to an integral binary64.
// Depends on fp64ri_pkg.
//
// Usage: input channel i_valid/o_ready carries i_value_bits and i_round_mode;
// output channel o_valid/i_ready carries o_result_bits, one result per
// input transaction, in order.
// Pipeline of three register stages: stage 1 decodes the exponent and
// builds the dead-bit mask, stage 2 forms the truncated magnitude and the
// half/below flags and the bump decision, stage 3 adds the unit and holds
// the result. One transaction is accepted every cycle while the output
// does not stall. The 63-bit add in stage 3 is the longest path.
// Reset clears all stage valid bits; no transaction is in flight after it.
// When the receiver holds i_ready low, the pipeline fills its empty slots
// and then stops with o_ready low; nothing is dropped or repeated.
`default_nettype none
module fp64_round_to_integral (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [63:0] i_value_bits,
    input  wire  [2:0]  i_round_mode,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_result_bits
);
    // stage enables: a stage advances if the next is empty or advancing
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;
    assign en3 = !r_v3 || i_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // stage 1: classify, build dead mask
    logic [10:0] efield;
    logic [5:0]  dead;
    logic        n_pass, n_small;
    logic [51:0] n_dmask;
    always_comb begin
        efield  = i_value_bits[62:52];
        n_pass  = (efield == fp64ri_pkg::EXP_MAX) || (efield >= 11'd1075);
        n_small = efield < fp64ri_pkg::EXP_BIAS;
        dead    = 6'd52 - 6'(efield - fp64ri_pkg::EXP_BIAS);
        if (n_small || n_pass) n_dmask = '0;
        else n_dmask = 52'((64'd1 << dead) - 64'd1);
    end

    logic [63:0] r_bits1;
    logic [2:0]  r_mode1;
    logic        r_pass1, r_small1;
    logic [51:0] r_dmask1;
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_bits1  <= i_value_bits;
            r_mode1  <= i_round_mode;
            r_pass1  <= n_pass;
            r_small1 <= n_small;
            r_dmask1 <= n_dmask;
        end
    end

    // stage 2: truncate, half/below flags, bump decision
    logic [51:0] dbits, hbit, lmask;
    logic        half, below, neg, n_bump;
    logic [62:0] n_mag, n_unit;
    always_comb begin
        hbit  = r_dmask1 ^ (r_dmask1 >> 1);
        lmask = r_dmask1 >> 1;
        dbits = r_bits1[51:0] & r_dmask1;
        neg   = r_bits1[63];
        if (r_small1) begin
            half  = r_bits1[62:52] == (fp64ri_pkg::EXP_BIAS - 11'd1);
            below = half ? (r_bits1[51:0] != '0) : (r_bits1[62:0] != '0);
            n_mag = '0;
            n_unit = fp64ri_pkg::ONE_MAG;
        end else begin
            half  = (dbits & hbit) != '0;
            below = (dbits & lmask) != '0;
            n_mag = r_bits1[62:0] & ~{11'd0, r_dmask1};
            n_unit = {11'd0, hbit} << 1;
        end
        unique case (r_mode1)
            fp64ri_pkg::MODE_UP:   n_bump = !neg && (half || below);
            fp64ri_pkg::MODE_DOWN: n_bump = neg && (half || below);
            fp64ri_pkg::MODE_NEAR,
            fp64ri_pkg::MODE_AWAY: n_bump = half;
            default:               n_bump = 1'b0;
        endcase
        if (r_pass1) begin
            n_bump = 1'b0;
            n_mag  = r_bits1[62:0];
        end
    end

    logic        r_sign2, r_bump2;
    logic [62:0] r_mag2, r_unit2;
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_sign2 <= r_bits1[63];
            r_bump2 <= n_bump;
            r_mag2  <= n_mag;
            r_unit2 <= n_unit;
        end
    end

    // stage 3: apply the bump; carry ripples into the exponent
    logic [63:0] r_res3;
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_res3 <= {r_sign2, r_bump2 ? r_mag2 + r_unit2 : r_mag2};
        end
    end
    assign o_result_bits = r_res3;

    // a stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_result_bits))
        else $error("result changed under stall");
    // stalled output with full stages blocks input
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && !i_ready |-> !o_ready)
        else $error("input accepted into full pipeline");
    // sign is always preserved
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en3 && r_v2 |=> o_result_bits[63] == $past(r_sign2))
        else $error("sign lost");
endmodule
`default_nettype wire
